// ===== design/tgp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgp_pkg
// Shared types and constants for the toroidal gradient propagation block.
// ----------------------------------------------------------------------------
package tgp_pkg;

  localparam int WidthLog2  = 6;
  localparam int HeightLog2 = 6;
  localparam int AddrW      = WidthLog2 + HeightLog2;
  localparam int Cells      = 1 << AddrW;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_RUN   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_MODE = 2'd0,
    REG_WALL = 2'd1,
    REG_OPEN = 2'd2,
    REG_NONE = 2'd3
  } reg_idx_t;

  // sequencer states of the sweep engine
  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_FETCH, ST_CTR, ST_NB, ST_WB, ST_RESP
  } eng_state_t;

  // configuration seen by the sweep engine
  typedef struct packed {
    logic       mode;
    logic [7:0] wall_marker;
    logic [7:0] open_marker;
  } cfg_t;

  // neighbour offset: -1, 0 or +1, as two-bit signed codes
  function automatic logic signed [1:0] nb_dx(input logic [1:0] sweep,
                                              input logic [1:0] i);
    logic signed [1:0] r;
    r = 2'sd0;
    case ({sweep, i})
      4'h0: r = -2'sd1; 4'h1: r = 2'sd0;  4'h2: r = 2'sd1;  4'h3: r = -2'sd1;
      4'h4: r = 2'sd1;  4'h5: r = 2'sd0;  4'h6: r = -2'sd1; 4'h7: r = -2'sd1;
      4'h8: r = -2'sd1; 4'h9: r = -2'sd1; 4'ha: r = -2'sd1; 4'hb: r = 2'sd0;
      4'hc: r = 2'sd1;  4'hd: r = 2'sd1;  4'he: r = 2'sd1;  4'hf: r = 2'sd0;
      default: r = 2'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] nb_dy(input logic [1:0] sweep,
                                              input logic [1:0] i);
    logic signed [1:0] r;
    r = 2'sd0;
    case ({sweep, i})
      4'h0: r = -2'sd1; 4'h1: r = -2'sd1; 4'h2: r = -2'sd1; 4'h3: r = 2'sd0;
      4'h4: r = 2'sd1;  4'h5: r = 2'sd1;  4'h6: r = 2'sd1;  4'h7: r = 2'sd0;
      4'h8: r = -2'sd1; 4'h9: r = 2'sd1;  4'ha: r = 2'sd0;  4'hb: r = -2'sd1;
      4'hc: r = -2'sd1; 4'hd: r = 2'sd0;  4'he: r = 2'sd1;  4'hf: r = -2'sd1;
      default: r = 2'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/tgp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgp_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module tgp_ram #(
  parameter int DataW = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [DataW-1:0]         wdata,
  output logic [DataW-1:0]         rdata
);

  logic [DataW-1:0] mem [Depth];

  // one access per cycle, read data registered and valid in the cycle after the access
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/tgp_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgp_engine
// Command sequencer: cell write, cell read and the four in-place sweeps,
// all through one grid memory port.
// ----------------------------------------------------------------------------
module tgp_engine import tgp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  logic [1:0]         cmd_op,
  input  logic [AddrW-1:0]   cmd_addr,
  input  logic [7:0]         cmd_value,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [7:0]         res_read_value,
  output logic               res_run_done
);

  eng_state_t            state_r, state_nxt;
  logic [1:0]            sweep_r, sweep_nxt;
  logic [WidthLog2-1:0]  x_r, x_nxt;
  logic [HeightLog2-1:0] y_r, y_nxt;
  logic [AddrW-1:0]      cnt_r, cnt_nxt;
  logic [2:0]            nb_r, nb_nxt;
  logic [7:0]            m_r, m_nxt;
  logic [7:0]            rv_r, rv_nxt;
  logic                  rd_r, rd_nxt;
  logic                  advance;
  logic                  last_cell;

  logic                  we;
  logic [AddrW-1:0]      addr;
  logic [7:0]            wdata, rdata;

  tgp_ram #(.DataW(8), .Depth(Cells)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // neighbour address for neighbour index nb_r
  logic signed [1:0]     dx, dy;
  logic [WidthLog2-1:0]  nx;
  logic [HeightLog2-1:0] ny;
  logic                  skip;
  logic [7:0]            v_inc;

  always_comb begin
    dx = nb_dx(sweep_r, nb_r[1:0]);
    dy = nb_dy(sweep_r, nb_r[1:0]);
    nx = x_r + {{(WidthLog2-2){dx[1]}}, dx};
    ny = y_r + {{(HeightLog2-2){dy[1]}}, dy};
    skip = cfg.mode ? (rdata == cfg.open_marker)
                    : (rdata == 8'd0 || rdata == cfg.wall_marker);
    v_inc = rdata + 8'd1;
  end

  // position of visit number cnt_r within a sweep (skewed diagonal)
  logic [HeightLog2-1:0] a_y, k_y, row_a, pos_y;
  logic [WidthLog2-1:0]  a_x, k_x, col_a, pos_x;
  always_comb begin
    a_y = cnt_r[AddrW-1:WidthLog2];
    k_x = cnt_r[WidthLog2-1:0];
    a_x = cnt_r[AddrW-1:HeightLog2];
    k_y = cnt_r[HeightLog2-1:0];
    row_a = (sweep_r == 2'd1) ? ~a_y : a_y;
    col_a = (sweep_r == 2'd3) ? ~a_x : a_x;
    if (!sweep_r[1]) begin
      pos_y = row_a;
      pos_x = WidthLog2'(row_a) + k_x;
    end else begin
      pos_x = col_a;
      pos_y = HeightLog2'(col_a) + k_y;
    end
    last_cell = (&cnt_r) && (sweep_r == 2'd3);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    sweep_nxt = sweep_r;
    x_nxt = x_r; y_nxt = y_r;
    cnt_nxt = cnt_r; nb_nxt = nb_r;
    m_nxt = m_r;
    rv_nxt = rv_r; rd_nxt = rd_r;
    advance = 1'b0;
    we = 1'b0;
    addr = {y_r, x_r};
    wdata = cmd_value;
    cmd_ready = (state_r == ST_IDLE);
    res_valid = (state_r == ST_RESP);
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          rv_nxt = 8'd0;
          rd_nxt = 1'b0;
          addr = cmd_addr;
          case (cmd_op)
            OP_WRITE: begin we = 1'b1; state_nxt = ST_RESP; end
            OP_READ:  state_nxt = ST_READ;
            OP_RUN: begin
              sweep_nxt = 2'd0;
              cnt_nxt = '0;
              state_nxt = ST_FETCH;
            end
            default:  state_nxt = ST_RESP;
          endcase
        end
      end
      ST_READ: begin
        rv_nxt = rdata;
        state_nxt = ST_RESP;
      end
      ST_FETCH: begin
        // read the center cell of this visit
        addr = {pos_y, pos_x};
        x_nxt = pos_x; y_nxt = pos_y;
        nb_nxt = 3'd0;
        state_nxt = ST_CTR;
      end
      ST_CTR: begin
        m_nxt = v_inc;
        if (skip) begin
          advance = 1'b1;
        end else begin
          addr = {ny, nx};
          nb_nxt = 3'd1;
          state_nxt = ST_NB;
        end
      end
      ST_NB: begin
        // compare the neighbour read in the previous cycle
        if (rdata > m_r) m_nxt = rdata;
        if (nb_r == 3'd4) begin
          state_nxt = ST_WB;
        end else begin
          addr = {ny, nx};
          nb_nxt = nb_r + 3'd1;
        end
      end
      ST_WB: begin
        // write back with the floor of the active variant
        we = 1'b1;
        if (cfg.mode) wdata = (m_r == 8'd0) ? 8'd0 : m_r - 8'd1;
        else          wdata = (m_r == 8'd1) ? 8'd1 : m_r - 8'd1;
        advance = 1'b1;
      end
      ST_RESP: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    // step to the next visit, or finish after the last cell of the last sweep
    if (advance) begin
      cnt_nxt = cnt_r + AddrW'(1);
      if (&cnt_r) sweep_nxt = sweep_r + 2'd1;
      if (last_cell) begin
        rd_nxt = 1'b1;
        state_nxt = ST_RESP;
      end else begin
        state_nxt = ST_FETCH;
      end
    end
  end

  assign res_read_value = rv_r;
  assign res_run_done   = rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sweep_r <= 2'd0;
      cnt_r   <= '0;
      nb_r    <= 3'd0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      cnt_r   <= cnt_nxt;
      nb_r    <= nb_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt;
    m_r <= m_nxt;
    rv_r <= rv_nxt; rd_r <= rd_nxt;
  end

  // a result is offered only after an accepted command
  a_resp_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_valid) |-> $past(state_r) != ST_IDLE || $past(cmd_valid))
    else $error("result without command");
  // memory is written only while busy or on a write command
  a_we_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == ST_WB) || (state_r == ST_IDLE && cmd_op == OP_WRITE))
    else $error("stray memory write");
  // result holds until taken
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res_read_value))
    else $error("result dropped");

endmodule

// ===== design/toroidal_gradient_propagation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toroidal_gradient_propagation
// Wrapping gradient grid with cell access and four-pass in-place propagation.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid/in_stall) carries one command per transfer:
//   write cell, read cell or run. Every command produces exactly one
//   transfer on the output channel (out_valid/out_stall).
//   A write result is offered in the cycle after the command transfer, a
//   read result after the ST_READ state; the next command is taken the
//   cycle after the result transfer. A run visits 4 sweeps x Cells cells;
//   an updated cell takes a center read, four neighbour reads through the
//   single grid memory port and a write back, a skipped cell only the
//   center read.
//   The block takes one command at a time; while a result waits on
//   out_stall no new command is accepted.
//   Reset clears the configuration to mode 0 with both markers at 255; the
//   grid content is undefined until written, no clearing pass runs.
//   Configuration is through the cfg_ APB port, registers at 0x0, 0x4, 0x8.
// ----------------------------------------------------------------------------
module toroidal_gradient_propagation import tgp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [5:0]  in_cell_x,
  input  logic [5:0]  in_cell_y,
  input  logic [7:0]  in_cell_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_value,
  output logic        out_run_done,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t cfg_r;
  logic ready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{mode: 1'b0, wall_marker: 8'hff, open_marker: 8'hff};
    end else if (cfg_psel && cfg_penable && cfg_pwrite
                 && cfg_paddr[1:0] == 2'b00) begin
      case (reg_idx_t'(cfg_paddr[3:2]))
        REG_MODE: cfg_r.mode        <= cfg_pwdata[0];
        REG_WALL: cfg_r.wall_marker <= cfg_pwdata[7:0];
        REG_OPEN: cfg_r.open_marker <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    cfg_prdata = 32'd0;
    case (reg_idx_t'(cfg_paddr[3:2]))
      REG_MODE: cfg_prdata = {31'd0, cfg_r.mode};
      REG_WALL: cfg_prdata = {24'd0, cfg_r.wall_marker};
      REG_OPEN: cfg_prdata = {24'd0, cfg_r.open_marker};
      default:  cfg_prdata = 32'd0;
    endcase
  end
  assign cfg_pready = 1'b1;

  tgp_engine u_engine (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .cmd_valid(in_valid), .cmd_ready(ready), .cmd_op(in_opcode),
    .cmd_addr({in_cell_y[HeightLog2-1:0], in_cell_x[WidthLog2-1:0]}),
    .cmd_value(in_cell_value),
    .res_valid(out_valid), .res_ready(!out_stall),
    .res_read_value(out_read_value), .res_run_done(out_run_done)
  );

  assign in_stall = !ready;

endmodule
